// File: rtl/pkc_pkg.sv
// shared types and constants for packet class statistics
`timescale 1ns / 1ps
`default_nettype none
package pkc_pkg;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] REG_ETH_MODE = 2'd0;
	localparam logic [1:0] REG_LINK_LEN = 2'd1;
	localparam logic [1:0] REG_DIR_EN   = 2'd2;
	localparam logic [1:0] REG_STA_MAC  = 2'd3;

	localparam logic [3:0] V_SHORT    = 4'd0;
	localparam logic [3:0] V_HDR_ONLY = 4'd1;
	localparam logic [3:0] V_TRUNC    = 4'd2;
	localparam logic [3:0] V_NOT_IP   = 4'd3;
	localparam logic [3:0] V_IP4      = 4'd4;
	localparam logic [3:0] V_IP6      = 4'd7;

	localparam int NUM_COUNTERS = 29;
	localparam logic [4:0] SET_SIZE  = 5'd14;
	localparam logic [4:0] ERR_INDEX = 5'd28;
	localparam logic [4:0] K_BYTES   = 5'd0;
	localparam logic [4:0] K_PKTS    = 5'd1;
	localparam logic [4:0] K_IP4     = 5'd2;
	localparam logic [4:0] K_IP6     = 5'd4;
	localparam logic [4:0] K_TCP     = 5'd6;
	localparam logic [4:0] K_NOTIP   = 5'd12;

	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [15:0] ETYPE_IP4  = 16'h0800;
	localparam logic [15:0] ETYPE_IP6  = 16'h86dd;
	localparam logic [3:0]  IP4_VER    = 4'h4;
	localparam logic [3:0]  IP6_VER    = 4'h6;
	localparam logic [16:0] IP6_HDR_LEN = 17'd40;

	typedef struct packed {
		logic        is_read;
		logic [4:0]  idx;
		logic [3:0]  verdict;
		logic        dir;
		logic [15:0] psize;
		logic [7:0]  proto;
	} job_t;

	typedef struct packed {
		logic        result_kind;
		logic [3:0]  verdict;
		logic        direction;
		logic [15:0] payload_size;
		logic [7:0]  protocol;
		logic [63:0] counter_value;
	} result_t;

	function automatic logic [1:0] transport_code(input logic [7:0] p);
		logic [1:0] c;
		if (p == PROTO_TCP) c = 2'd0;
		else if (p == PROTO_UDP) c = 2'd1;
		else c = 2'd2;
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/pkc_fifo.sv
// two-entry queue with registered full and empty
`timescale 1ns / 1ps
`default_nettype none
module pkc_fifo #(
	parameter type T = logic
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire T     wr_data,
	output logic      full,
	input  wire logic rd,
	output T          rd_data,
	output logic      empty
);
	T           mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= !wp_q;
			if (do_rd) rp_q <= !rp_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

// File: rtl/pkc_front.sv
// front end: header capture and packet classification
`timescale 1ns / 1ps
`default_nettype none
module pkc_front
	import pkc_pkg::*;
#(
	parameter int MAX_LINK_HEADER = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic [15:0] wire_length,
	input  wire logic [4:0]  counter_index,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [47:0] wr_data,
	output logic             job_valid,
	output job_t             job
);
	logic        eth_mode_q, dir_en_q;
	logic [6:0]  link_len_q;
	logic [47:0] sta_mac_q;

	logic [15:0] pos_q;
	logic [47:0] smac_q, smac_n;
	logic [15:0] etype_q, etype_n;
	logic [7:0]  nfb_q, nfb_n;
	logic [15:0] tlen_q, tlen_n;
	logic [7:0]  proto4_q, proto4_n;
	logic [7:0]  nh6_q, nh6_n;

	logic [6:0]  l;
	logic [16:0] p, lx, caplen;
	logic [15:0] etype_eff;
	logic        eth, dir;
	logic [3:0]  verdict;
	logic [7:0]  proto;
	logic [15:0] psize;
	logic        ip6_trunc, ip4_trunc;

	always_comb begin
		if ({1'b0, link_len_q} > 8'(MAX_LINK_HEADER)) l = 7'(MAX_LINK_HEADER);
		else l = link_len_q;
		p  = {1'b0, pos_q};
		lx = 17'(l);
		smac_n = smac_q; etype_n = etype_q; nfb_n = nfb_q;
		tlen_n = tlen_q; proto4_n = proto4_q; nh6_n = nh6_q;
		if (p >= 17'd6 && p < 17'd12) smac_n = {smac_q[39:0], data_byte};
		if (p == 17'd12) etype_n[15:8] = data_byte;
		if (p == 17'd13) etype_n[7:0] = data_byte;
		if (p == lx) nfb_n = data_byte;
		if (p == lx + 17'd2) tlen_n[15:8] = data_byte;
		if (p == lx + 17'd3) tlen_n[7:0] = data_byte;
		if (p == lx + 17'd6) nh6_n = data_byte;
		if (p == lx + 17'd9) proto4_n = data_byte;

		caplen = (pos_q == 16'hffff) ? 17'hffff : p + 17'd1;
		eth = eth_mode_q;
		etype_eff = eth ? etype_n : ETYPE_IP4;
		dir = eth && dir_en_q && (smac_n == sta_mac_q);
		psize = (wire_length >= 16'(l)) ? wire_length - 16'(l) : 16'd0;
		ip6_trunc = lx + IP6_HDR_LEN > caplen;
		ip4_trunc = (lx + 17'({nfb_n[3:0], 2'b00}) > caplen) ||
			(lx + 17'(tlen_n) > caplen);
		proto = 8'd0;
		if (lx > caplen) begin
			verdict = V_SHORT;
			dir = 1'b0;
			psize = 16'd0;
		end else if (lx == caplen) begin
			verdict = V_HDR_ONLY;
		end else if (etype_eff == ETYPE_IP4 && nfb_n[7:4] == IP4_VER) begin
			if (ip4_trunc) verdict = V_TRUNC;
			else begin
				verdict = V_IP4 + 4'(transport_code(proto4_n));
				proto = proto4_n;
			end
		end else if (etype_eff == ETYPE_IP4 || etype_eff == ETYPE_IP6) begin
			if (ip6_trunc) verdict = V_TRUNC;
			else if (nfb_n[7:4] != IP6_VER) verdict = V_NOT_IP;
			else begin
				verdict = V_IP6 + 4'(transport_code(nh6_n));
				proto = nh6_n;
			end
		end else begin
			verdict = V_NOT_IP;
		end

		job_valid = accept && (kind == KIND_READ || last_byte);
		job.is_read = kind == KIND_READ;
		job.idx     = counter_index;
		job.verdict = verdict;
		job.dir     = dir;
		job.psize   = psize;
		job.proto   = proto;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eth_mode_q <= 1'b1;
			link_len_q <= 7'd14;
			dir_en_q   <= 1'b0;
			sta_mac_q  <= 48'd0;
			pos_q      <= 16'd0;
			smac_q     <= 48'd0;
			etype_q    <= 16'd0;
			nfb_q      <= 8'd0;
			tlen_q     <= 16'd0;
			proto4_q   <= 8'd0;
			nh6_q      <= 8'd0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_ETH_MODE: eth_mode_q <= wr_data[0];
					REG_LINK_LEN: link_len_q <= wr_data[6:0];
					REG_DIR_EN:   dir_en_q   <= wr_data[0];
					REG_STA_MAC:  sta_mac_q  <= wr_data;
					default: ;
				endcase
			end
			if (accept && kind == KIND_BYTE) begin
				if (last_byte) begin
					pos_q    <= 16'd0;
					smac_q   <= 48'd0;
					etype_q  <= 16'd0;
					nfb_q    <= 8'd0;
					tlen_q   <= 16'd0;
					proto4_q <= 8'd0;
					nh6_q    <= 8'd0;
				end else begin
					if (pos_q != 16'hffff) pos_q <= pos_q + 16'd1;
					smac_q   <= smac_n;
					etype_q  <= etype_n;
					nfb_q    <= nfb_n;
					tlen_q   <= tlen_n;
					proto4_q <= proto4_n;
					nh6_q    <= nh6_n;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/pkc_back.sv
// back end: statistics counters and counter reads
`timescale 1ns / 1ps
`default_nettype none
module pkc_back
	import pkc_pkg::*;
#(
	parameter int COUNTER_BITS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  wire job_t job,
	output logic      job_take,
	input  wire logic res_full,
	output logic      res_valid,
	output result_t   res
);
	logic [COUNTER_BITS-1:0] cnt_q [NUM_COUNTERS];
	logic [COUNTER_BITS-1:0] inc   [NUM_COUNTERS];
	logic [COUNTER_BITS-1:0] ps;
	logic [4:0]              base;
	logic [4:0]              cls;
	logic                    apply;

	assign job_take  = job_valid && !res_full;
	assign res_valid = job_take;
	assign apply     = job_take && !job.is_read;

	always_comb begin
		for (int i = 0; i < NUM_COUNTERS; i++) inc[i] = '0;
		ps   = COUNTER_BITS'(job.psize);
		base = job.dir ? SET_SIZE : 5'd0;
		cls  = K_NOTIP;
		if (job.verdict >= V_IP6) cls = K_TCP + 5'({job.verdict - V_IP6, 1'b0});
		else if (job.verdict >= V_IP4) cls = K_TCP + 5'({job.verdict - V_IP4, 1'b0});
		unique case (job.verdict)
			V_SHORT: inc[ERR_INDEX] = COUNTER_BITS'(1);
			V_HDR_ONLY: begin
				inc[ERR_INDEX]       = COUNTER_BITS'(1);
				inc[base + K_BYTES]  = ps;
			end
			V_TRUNC: begin
				inc[base + K_BYTES] = ps;
				inc[base + K_PKTS]  = COUNTER_BITS'(1);
			end
			default: begin
				inc[base + K_BYTES]    = ps;
				inc[base + K_PKTS]     = COUNTER_BITS'(1);
				inc[base + cls]        = COUNTER_BITS'(1);
				inc[base + cls + 5'd1] = ps;
				if (job.verdict >= V_IP6) begin
					inc[base + K_IP6]        = COUNTER_BITS'(1);
					inc[base + K_IP6 + 5'd1] = ps;
				end else if (job.verdict >= V_IP4) begin
					inc[base + K_IP4]        = COUNTER_BITS'(1);
					inc[base + K_IP4 + 5'd1] = ps;
				end
			end
		endcase

		res.result_kind = job.is_read;
		if (job.is_read) begin
			res.verdict      = 4'd0;
			res.direction    = 1'b0;
			res.payload_size = 16'd0;
			res.protocol     = 8'd0;
			res.counter_value = (job.idx <= ERR_INDEX) ? 64'(cnt_q[job.idx]) : 64'd0;
		end else begin
			res.verdict       = job.verdict;
			res.direction     = job.dir;
			res.payload_size  = job.psize;
			res.protocol      = job.proto;
			res.counter_value = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) cnt_q[i] <= '0;
		end else if (apply) begin
			for (int i = 0; i < NUM_COUNTERS; i++) cnt_q[i] <= cnt_q[i] + inc[i];
		end
	end
endmodule
`default_nettype wire

// File: rtl/packet_class_statistics.sv
// top level of the packet class statistics block
`timescale 1ns / 1ps
`default_nettype none
// Packet bytes (kind 0) and counter reads (kind 1) are pushed one beat per
// cycle. The front end captures header fields and classifies a packet on its
// last byte, then hands a job through a two-entry queue to the back end, which
// updates the 29 counters and queues the verdict or read data in a two-entry
// result queue. A beat is taken every cycle while the job queue has room. A
// verdict or read result passes through the job queue and then the result
// queue. Reads return counter values that include all earlier packets.
module packet_class_statistics
	import pkc_pkg::*;
#(
	parameter int MAX_LINK_HEADER = 64,
	parameter int COUNTER_BITS    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic [15:0] wire_length,
	input  wire logic [4:0]  counter_index,
	output logic             empty,
	input  wire logic        pop,
	output logic             result_kind,
	output logic [3:0]       verdict,
	output logic             direction,
	output logic [15:0]      payload_size,
	output logic [7:0]       protocol,
	output logic [63:0]      counter_value,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [47:0] wr_data
);
	logic    fe_valid, jq_empty, take, res_valid, rq_full;
	job_t    fe_job, jq_job;
	result_t res, rq_out;

	pkc_front #(.MAX_LINK_HEADER(MAX_LINK_HEADER)) u_front (
		.clk, .arst_n,
		.accept(push && !full),
		.kind, .data_byte, .last_byte, .wire_length, .counter_index,
		.wr_en, .wr_index, .wr_data,
		.job_valid(fe_valid), .job(fe_job)
	);

	pkc_fifo #(.T(job_t)) u_jobq (
		.clk, .arst_n,
		.wr(fe_valid), .wr_data(fe_job), .full(full),
		.rd(take), .rd_data(jq_job), .empty(jq_empty)
	);

	pkc_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
		.clk, .arst_n,
		.job_valid(!jq_empty), .job(jq_job), .job_take(take),
		.res_full(rq_full), .res_valid(res_valid), .res(res)
	);

	pkc_fifo #(.T(result_t)) u_resq (
		.clk, .arst_n,
		.wr(res_valid), .wr_data(res), .full(rq_full),
		.rd(pop), .rd_data(rq_out), .empty(empty)
	);

	assign result_kind   = rq_out.result_kind;
	assign verdict       = rq_out.verdict;
	assign direction     = rq_out.direction;
	assign payload_size  = rq_out.payload_size;
	assign protocol      = rq_out.protocol;
	assign counter_value = rq_out.counter_value;
endmodule
`default_nettype wire
